// ----- hw/rtl/spfp_pkg.sv -----
// ----------------------------------------------------------------------------
// spfp_pkg
// Shared types and constants for the serial pose frame parser.
// ----------------------------------------------------------------------------
package spfp_pkg;

  // frame framing bytes
  localparam logic [7:0] HDR_POSE    = 8'hAA;
  localparam logic [7:0] HDR_IMAGE   = 8'h55;
  localparam logic [7:0] HDR_CAPTURE = 8'hFC;
  localparam logic [7:0] TAIL_FIRST  = 8'h0A;
  localparam logic [7:0] TAIL_SECOND = 8'h0D;

  // payload sizes in bytes
  localparam int POSE_BYTES  = 6;
  localparam int IMAGE_BYTES = 4;
  localparam int PL_DEPTH    = POSE_BYTES;
  localparam int PL_IDX_W    = $clog2(PL_DEPTH);
  localparam int CNT_W       = 3;

  // image error bias
  localparam int IMG_BIAS = 12;

  // calibration
  localparam int CAL_FRAMES = 100;
  localparam int CAL_W      = $clog2(CAL_FRAMES + 1);
  localparam int ACC_W      = 24;

  // sum / CAL_FRAMES done as (|sum| * DIV_MULT) >> DIV_SHIFT, exact for |sum| < 2^23
  localparam int DIV_SHIFT  = 30;
  localparam int DIV_MULT   = ((2 ** DIV_SHIFT) + CAL_FRAMES - 1) / CAL_FRAMES;
  localparam int MULT_W     = $clog2(DIV_MULT + 1);
  localparam int PROD_W     = ACC_W + MULT_W;

  // output widths
  localparam int POS_W = 18;
  localparam int ERR_W = 17;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_POSE  = 5'b00010,
    ST_IMAGE = 5'b00100,
    ST_TAIL1 = 5'b01000,
    ST_TAIL2 = 5'b10000
  } parse_state_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_POSE  = 2'd1,
    KIND_IMAGE = 2'd2
  } frame_kind_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_POSE    = 2'd1,
    EV_IMAGE   = 2'd2,
    EV_CAPTURE = 2'd3
  } event_t;

endpackage

// ----- hw/rtl/serial_pose_frame_parser.sv -----
// ----------------------------------------------------------------------------
// serial_pose_frame_parser
// Byte-wise parser for pose, image and capture frames from a serial link.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) carries one received byte per
//   transaction. Output channel (out_valid/out_ready) returns exactly one
//   result per input byte: accepted flag, event code and the pose / image
//   error fields (zero when not valid for the event).
//   The result is registered when its byte is taken. Throughput is one byte
//   per cycle while the receiver takes results, set by the single result
//   register; a new byte is taken while the previous result is being taken.
//   When the receiver stalls, the result register holds and in_ready drops
//   until the result is taken.
//   The first CAL_FRAMES good pose frames are summed; the last of them starts
//   a divide (one multiply stage, one write-back) that turns the sums into
//   offsets, long before the next pose frame can complete.
//   Reset returns the parser to idle, clears the calibration count and sums
//   and empties the result register. Payload bytes are not reset.
// ----------------------------------------------------------------------------
module serial_pose_frame_parser (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             accepted,
  output logic [1:0]                       event_res,
  output logic signed [spfp_pkg::POS_W-1:0] pos_x,
  output logic signed [spfp_pkg::POS_W-1:0] pos_y,
  output logic signed [spfp_pkg::POS_W-1:0] heading,
  output logic signed [spfp_pkg::ERR_W-1:0] err_x,
  output logic signed [spfp_pkg::ERR_W-1:0] err_y
);
  import spfp_pkg::*;

  parse_state_t            parse_state, parse_state_next;
  frame_kind_t             frame_kind, frame_kind_next;
  logic [CNT_W-1:0]        byte_count, byte_count_next;
  logic [7:0]              payload_bytes [PL_DEPTH];
  logic [CAL_W-1:0]        calib_count;
  logic signed [ACC_W-1:0] x_offset_acc, y_offset_acc, yaw_offset_acc;

  logic                    in_fire;
  logic                    pl_wr;
  logic                    cal_add;
  logic                    cal_last;
  logic                    div_go, div_wb;
  logic [PROD_W-1:0]       x_prod, y_prod, yaw_prod;
  logic                    x_neg, y_neg, yaw_neg;

  logic                    accepted_next;
  event_t                  ev_next;
  logic signed [POS_W-1:0] pos_x_next, pos_y_next, heading_next;
  logic signed [ERR_W-1:0] err_x_next, err_y_next;

  logic signed [15:0]      w0, w1, w2;
  logic signed [ACC_W-1:0] x_ext, y_ext, yaw_ext;
  logic signed [ACC_W-1:0] x_diff, y_diff, yaw_diff;
  logic [CAL_W-1:0]        calib_inc;
  logic [CNT_W-1:0]        byte_inc;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // little-endian payload words
  assign w0 = {payload_bytes[1], payload_bytes[0]};
  assign w1 = {payload_bytes[3], payload_bytes[2]};
  assign w2 = {payload_bytes[5], payload_bytes[4]};

  assign x_ext   = -ACC_W'(w0);
  assign y_ext   = ACC_W'(w1);
  assign yaw_ext = ACC_W'(w2);

  assign x_diff   = x_ext - x_offset_acc;
  assign y_diff   = y_ext - y_offset_acc;
  assign yaw_diff = yaw_ext - yaw_offset_acc;

  assign calib_inc = calib_count + CAL_W'(1);
  assign byte_inc  = byte_count + CNT_W'(1);

  always_comb begin
    parse_state_next = ST_IDLE;
    frame_kind_next  = frame_kind;
    byte_count_next  = byte_count;
    pl_wr            = 1'b0;
    cal_add          = 1'b0;
    cal_last         = 1'b0;
    accepted_next    = 1'b1;
    ev_next          = EV_NONE;
    pos_x_next       = '0;
    pos_y_next       = '0;
    heading_next     = '0;
    err_x_next       = '0;
    err_y_next       = '0;
    case (parse_state)
      ST_POSE, ST_IMAGE: begin
        pl_wr           = 1'b1;
        byte_count_next = byte_inc;
        if ((parse_state == ST_POSE  && byte_inc >= CNT_W'(POSE_BYTES)) ||
            (parse_state == ST_IMAGE && byte_inc >= CNT_W'(IMAGE_BYTES))) begin
          parse_state_next = ST_TAIL1;
        end else begin
          parse_state_next = parse_state;
        end
      end
      ST_TAIL1: begin
        if (rx_byte == TAIL_FIRST) begin
          parse_state_next = ST_TAIL2;
        end else begin
          accepted_next = 1'b0;
        end
      end
      ST_TAIL2: begin
        if (rx_byte != TAIL_SECOND) begin
          accepted_next = 1'b0;
        end else if (frame_kind == KIND_POSE) begin
          if (calib_count < CAL_W'(CAL_FRAMES)) begin
            cal_add  = 1'b1;
            cal_last = (calib_inc == CAL_W'(CAL_FRAMES));
          end else begin
            ev_next      = EV_POSE;
            pos_x_next   = x_diff[POS_W-1:0];
            pos_y_next   = y_diff[POS_W-1:0];
            heading_next = yaw_diff[POS_W-1:0];
          end
        end else if (frame_kind == KIND_IMAGE) begin
          ev_next    = EV_IMAGE;
          err_x_next = ERR_W'(w0) + ERR_W'(IMG_BIAS);
          err_y_next = ERR_W'(w1) - ERR_W'(IMG_BIAS);
        end
      end
      default: begin
        if (rx_byte == HDR_POSE) begin
          frame_kind_next  = KIND_POSE;
          parse_state_next = ST_POSE;
          byte_count_next  = '0;
        end else if (rx_byte == HDR_IMAGE) begin
          frame_kind_next  = KIND_IMAGE;
          parse_state_next = ST_IMAGE;
          byte_count_next  = '0;
        end else if (rx_byte == HDR_CAPTURE) begin
          ev_next = EV_CAPTURE;
        end else begin
          frame_kind_next = KIND_NONE;
          accepted_next   = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= ST_IDLE;
      frame_kind  <= KIND_NONE;
      byte_count  <= '0;
    end else if (in_fire) begin
      parse_state <= parse_state_next;
      frame_kind  <= frame_kind_next;
      byte_count  <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && pl_wr) begin
      payload_bytes[byte_count[PL_IDX_W-1:0]] <= rx_byte;
    end
  end

  // calibration sums, then the divide sequence overwrites them with averages
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_count    <= '0;
      x_offset_acc   <= '0;
      y_offset_acc   <= '0;
      yaw_offset_acc <= '0;
      div_go         <= 1'b0;
      div_wb         <= 1'b0;
    end else begin
      div_go <= in_fire && cal_last;
      div_wb <= div_go;
      if (in_fire && cal_add) begin
        calib_count    <= calib_inc;
        x_offset_acc   <= x_offset_acc + x_ext;
        y_offset_acc   <= y_offset_acc + y_ext;
        yaw_offset_acc <= yaw_offset_acc + yaw_ext;
      end else if (div_wb) begin
        x_offset_acc   <= x_neg   ? -ACC_W'(x_prod >> DIV_SHIFT)   : ACC_W'(x_prod >> DIV_SHIFT);
        y_offset_acc   <= y_neg   ? -ACC_W'(y_prod >> DIV_SHIFT)   : ACC_W'(y_prod >> DIV_SHIFT);
        yaw_offset_acc <= yaw_neg ? -ACC_W'(yaw_prod >> DIV_SHIFT) : ACC_W'(yaw_prod >> DIV_SHIFT);
      end
    end
  end

  // reciprocal multiply on magnitudes, truncation toward zero
  always_ff @(posedge clk) begin
    if (div_go) begin
      x_neg    <= x_offset_acc[ACC_W-1];
      y_neg    <= y_offset_acc[ACC_W-1];
      yaw_neg  <= yaw_offset_acc[ACC_W-1];
      x_prod   <= PROD_W'($unsigned(x_offset_acc[ACC_W-1] ? -x_offset_acc
                                                          : x_offset_acc))
                * PROD_W'(DIV_MULT);
      y_prod   <= PROD_W'($unsigned(y_offset_acc[ACC_W-1] ? -y_offset_acc
                                                          : y_offset_acc))
                * PROD_W'(DIV_MULT);
      yaw_prod <= PROD_W'($unsigned(yaw_offset_acc[ACC_W-1] ? -yaw_offset_acc
                                                            : yaw_offset_acc))
                * PROD_W'(DIV_MULT);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      accepted  <= accepted_next;
      event_res <= ev_next;
      pos_x     <= pos_x_next;
      pos_y     <= pos_y_next;
      heading   <= heading_next;
      err_x     <= err_x_next;
      err_y     <= err_y_next;
    end
  end

  // divide sequence only runs once calibration is complete
  a_div_after_cal: assert property (@(posedge clk) disable iff (rst)
    (div_go || div_wb) |-> calib_count == CAL_W'(CAL_FRAMES))
    else $error("offset divide outside end of calibration");

  a_div_seq: assert property (@(posedge clk) disable iff (rst)
    div_go |=> div_wb)
    else $error("divide write-back missing");

  // a pose result never uses raw sums
  a_pose_calibrated: assert property (@(posedge clk) disable iff (rst)
    (in_fire && ev_next == EV_POSE) |-> (!div_go && !div_wb &&
      calib_count == CAL_W'(CAL_FRAMES)))
    else $error("pose result before offsets were ready");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(POSE_BYTES))
    else $error("payload byte count out of range");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

// ----- bench/serial_pose_frame_parser_tb.sv -----
// ----------------------------------------------------------------------------
// serial_pose_frame_parser_tb
// Drives received bytes into the frame parser and checks every per-byte
// result against a cycle-free model of the frame grammar, the image error
// bias and the pose calibration offsets. Both channels idle and stall at
// random. The run includes a long output stall and a full drain.
// ----------------------------------------------------------------------------
module serial_pose_frame_parser_tb;
  import spfp_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 300;
  localparam int TARGET_ITEMS   = 900;

  typedef struct {
    logic                    acc;
    event_t                  ev;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] ph;
    logic signed [ERR_W-1:0] ex;
    logic signed [ERR_W-1:0] ey;
  } frame_result_t;

  class frame_result_scoreboard;
    parse_state_t  pstate;
    frame_kind_t   kind;
    int            nbytes;
    logic [7:0]    payload [POSE_BYTES];
    int            calib_frames;
    int            x_off;
    int            y_off;
    int            yaw_off;
    frame_result_t expected_results[$];
    int            errors;

    function new();
      pstate       = ST_IDLE;
      kind         = KIND_NONE;
      nbytes       = 0;
      calib_frames = 0;
      x_off        = 0;
      y_off        = 0;
      yaw_off      = 0;
      errors       = 0;
      foreach (payload[i]) payload[i] = 8'h00;
    endfunction

    function int word16(int i);
      return int'($signed({payload[2*i+1], payload[2*i]}));
    endfunction

    // advance the frame grammar by one byte and queue what it reports
    function void note_byte(logic [7:0] b);
      frame_result_t r;
      int x, y, yaw;
      r.acc = 1'b1;
      r.ev  = EV_NONE;
      r.px  = '0;
      r.py  = '0;
      r.ph  = '0;
      r.ex  = '0;
      r.ey  = '0;
      case (pstate)
        ST_POSE, ST_IMAGE: begin
          payload[nbytes] = b;
          nbytes++;
          if (nbytes >= ((pstate == ST_POSE) ? POSE_BYTES : IMAGE_BYTES))
            pstate = ST_TAIL1;
        end
        ST_TAIL1: begin
          if (b == TAIL_FIRST) begin
            pstate = ST_TAIL2;
          end else begin
            pstate = ST_IDLE;
            r.acc  = 1'b0;
          end
        end
        ST_TAIL2: begin
          pstate = ST_IDLE;
          if (b != TAIL_SECOND) begin
            r.acc = 1'b0;
          end else if (kind == KIND_POSE) begin
            x   = -word16(0);
            y   = word16(1);
            yaw = word16(2);
            if (calib_frames < CAL_FRAMES) begin
              x_off   += x;
              y_off   += y;
              yaw_off += yaw;
              calib_frames++;
              // last calibration frame turns sums into averages
              if (calib_frames == CAL_FRAMES) begin
                x_off   = x_off / CAL_FRAMES;
                y_off   = y_off / CAL_FRAMES;
                yaw_off = yaw_off / CAL_FRAMES;
              end
            end else begin
              r.px = POS_W'(x - x_off);
              r.py = POS_W'(y - y_off);
              r.ph = POS_W'(yaw - yaw_off);
              r.ev = EV_POSE;
            end
          end else if (kind == KIND_IMAGE) begin
            r.ex = ERR_W'(word16(0) + IMG_BIAS);
            r.ey = ERR_W'(word16(1) - IMG_BIAS);
            r.ev = EV_IMAGE;
          end
        end
        default: begin
          pstate = ST_IDLE;
          if (b == HDR_POSE) begin
            kind   = KIND_POSE;
            pstate = ST_POSE;
            nbytes = 0;
          end else if (b == HDR_IMAGE) begin
            kind   = KIND_IMAGE;
            pstate = ST_IMAGE;
            nbytes = 0;
          end else if (b == HDR_CAPTURE) begin
            r.ev = EV_CAPTURE;
          end else begin
            kind  = KIND_NONE;
            r.acc = 1'b0;
          end
        end
      endcase
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic signed [POS_W-1:0] want,
                                logic signed [POS_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic acc, logic [1:0] ev,
                               logic signed [POS_W-1:0] px,
                               logic signed [POS_W-1:0] py,
                               logic signed [POS_W-1:0] ph,
                               logic signed [ERR_W-1:0] ex,
                               logic signed [ERR_W-1:0] ey);
      frame_result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual accepted=%0b event=%0d",
                 $time, acc, ev);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      compare_field("accepted", e.acc, acc);
      compare_field("event_res", e.ev, ev);
      compare_field("pos_x", e.px, px);
      compare_field("pos_y", e.py, py);
      compare_field("heading", e.ph, ph);
      compare_field("err_x", e.ex, ex);
      compare_field("err_y", e.ey, ey);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid;
  logic                    in_ready;
  logic [7:0]              rx_byte;
  logic                    out_valid;
  logic                    out_ready;
  logic                    accepted;
  logic [1:0]              event_res;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] heading;
  logic signed [ERR_W-1:0] err_x;
  logic signed [ERR_W-1:0] err_y;

  frame_result_scoreboard sb = new();

  bit quiet_in;
  bit quiet_out;
  bit hold_rx;
  int items_sent;
  int idle_cycles = 0;

  serial_pose_frame_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .accepted  (accepted),
    .event_res (event_res),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .heading   (heading),
    .err_x     (err_x),
    .err_y     (err_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 39) == 0) quiet_in = !quiet_in;
    gap = quiet_in ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    items_sent++;
  endtask

  task automatic send_word(input logic [15:0] w);
    send_byte(w[7:0]);
    send_byte(w[15:8]);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] wrong_byte(input logic [7:0] good);
    logic [7:0] b;
    do b = 8'($urandom); while (b == good);
    return b;
  endfunction

  task automatic send_frame(input logic [7:0] hdr, input logic [7:0] t1,
                            input logic [7:0] t2);
    int nwords;
    nwords = (hdr == HDR_POSE) ? POSE_BYTES / 2 : IMAGE_BYTES / 2;
    send_byte(hdr);
    repeat (nwords) send_word(pick_word());
    send_byte(t1);
    send_byte(t2);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_rx) begin
        hold_rx = 1'b0;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else begin
        if ($urandom_range(0, 39) == 0) quiet_out = !quiet_out;
        stall = quiet_out ? 0 : $urandom_range(0, 4);
        repeat (stall) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(accepted, event_res, pos_x, pos_y, heading, err_x, err_y);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[serial_pose_frame_parser] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int  pick;
    int  junk_len;
    bit  hold_done;
    bit  drain_done;
    in_valid    = 1'b0;
    rx_byte     = 8'h00;
    hold_rx     = 1'b0;
    hold_done   = 1'b0;
    drain_done  = 1'b0;
    items_sent  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // rejected idle bytes and a capture
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_CAPTURE);
    // image frame with extreme words
    send_byte(HDR_IMAGE);
    send_word(16'h7FFF);
    send_word(16'h8000);
    send_byte(TAIL_FIRST);
    send_byte(TAIL_SECOND);
    // pose frame with extreme words, bad first tail byte
    send_byte(HDR_POSE);
    send_word(16'h8000);
    send_word(16'h7FFF);
    send_word(16'h8000);
    send_byte(TAIL_SECOND);
    // image frame, bad second tail byte
    send_byte(HDR_IMAGE);
    send_word(16'h3412);
    send_word(16'h7856);
    send_byte(TAIL_FIRST);
    send_byte(HDR_IMAGE);
    drain_results();

    // mostly good frames with broken tails, noise and junk runs mixed in
    while (items_sent < TARGET_ITEMS) begin
      if (!hold_done && items_sent >= 300) begin
        hold_rx   = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && items_sent >= 600) begin
        drain_results();
        drain_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame(HDR_POSE, TAIL_FIRST, TAIL_SECOND);
      end else if (pick < 75) begin
        send_frame(HDR_IMAGE, TAIL_FIRST, TAIL_SECOND);
      end else if (pick < 80) begin
        send_byte(HDR_CAPTURE);
      end else if (pick < 88) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 94) begin
        // good payload, broken tail
        if ($urandom_range(0, 1) == 0)
          send_frame($urandom_range(0, 1) ? HDR_POSE : HDR_IMAGE,
                     wrong_byte(TAIL_FIRST), 8'($urandom));
        else
          send_frame($urandom_range(0, 1) ? HDR_POSE : HDR_IMAGE,
                     TAIL_FIRST, wrong_byte(TAIL_SECOND));
      end else begin
        // header followed by a run of arbitrary bytes
        send_byte($urandom_range(0, 1) ? HDR_POSE : HDR_IMAGE);
        junk_len = $urandom_range(0, 10);
        repeat (junk_len) send_byte(8'($urandom));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("[serial_pose_frame_parser] OK");
    else
      $display("[serial_pose_frame_parser] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/spfp_pkg.sv
hw/rtl/serial_pose_frame_parser.sv
bench/serial_pose_frame_parser_tb.sv
